/* rtl/core/hrc_pkg.sv */
// ----------------------------------------------------------------------------
// hrc_pkg
// Shared widths, register codes and reset values of the hue ramp colormap.
// ----------------------------------------------------------------------------
package hrc_pkg;

	localparam int ENTRY_IDX_W = 12;
	localparam int STEP_W      = 17;
	localparam int Q16_W       = 16;
	localparam int CFG_IDX_W   = 8;
	localparam int CFG_DATA_W  = 17;

	// restoring divider: quotient bits per pipeline stage and stage count
	localparam int DIV_BITS   = 2;
	localparam int DIV_STAGES = Q16_W / DIV_BITS;

	localparam logic [STEP_W-1:0] ONE_Q16 = 17'h1_0000;

	localparam logic [STEP_W-1:0] RST_POSITION_STEP   = 17'd256;
	localparam logic [Q16_W-1:0]  RST_CONTRAST_BOTTOM = 16'd0;
	localparam logic [Q16_W-1:0]  RST_CONTRAST_TOP    = 16'hFFFF;
	localparam logic [Q16_W-1:0]  RST_BRIGHTNESS      = 16'hFFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POSITION_STEP   = 8'd0,
		REG_CONTRAST_BOTTOM = 8'd1,
		REG_CONTRAST_TOP    = 8'd2,
		REG_BRIGHTNESS      = 8'd3
	} cfg_reg_t;

	// hue sector: dominant component first, then the one that moves
	typedef enum logic [2:0] {
		SEC_R_G = 3'd0,
		SEC_G_R = 3'd1,
		SEC_G_B = 3'd2,
		SEC_B_G = 3'd3,
		SEC_B_R = 3'd4,
		SEC_R_B = 3'd5
	} sector_t;

endpackage

/* rtl/core/hrc_item_if.sv */
// ----------------------------------------------------------------------------
// hrc_item_if
// Request channel carrying one table entry index.
// ----------------------------------------------------------------------------
interface hrc_item_if;
	import hrc_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [ENTRY_IDX_W-1:0] entry_index;

	modport source (output valid, output entry_index, input ready);
	modport sink (input valid, input entry_index, output ready);
endinterface

/* rtl/core/hrc_result_if.sv */
// ----------------------------------------------------------------------------
// hrc_result_if
// Result channel carrying one Q0.16 RGB color.
// ----------------------------------------------------------------------------
interface hrc_result_if;
	import hrc_pkg::*;

	logic             valid;
	logic             ready;
	logic [Q16_W-1:0] red;
	logic [Q16_W-1:0] green;
	logic [Q16_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

/* rtl/core/hrc_cfg_if.sv */
// ----------------------------------------------------------------------------
// hrc_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface hrc_cfg_if;
	import hrc_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/hue_ramp_colormap.sv */
// ----------------------------------------------------------------------------
// hue_ramp_colormap
// Computes one RGB entry of a hue ramp color table per request.
// ----------------------------------------------------------------------------
// Each request carries a table index and returns one Q0.16 red, green, blue
// triple, in request order. The block is a 17-stage pipeline with no state
// between entries: one index is taken every cycle while the pipeline is not
// stalled. The hue divide is a restoring divider spread over 8 stages of
// 2 quotient bits each; the smoothstep and the value scaling run through
// registered multipliers. When result.ready is low, empty stages still fill,
// so up to 17 requests are held before item.ready drops. Registers are to be
// written through cfg only while the pipeline is empty; the block does not
// enforce it. cfg.ready is always high; writes to an unknown index are dropped.
module hue_ramp_colormap #(
	parameter int MAX_ENTRIES = 4096
) (
	input logic          clk,
	input logic          arst_n,
	hrc_item_if.sink     item,
	hrc_result_if.source result,
	hrc_cfg_if.sink      cfg
);
	import hrc_pkg::*;

	localparam int ST_IDX    = 1;
	localparam int ST_RANGE  = 2;
	localparam int DIV_FIRST = 3;
	localparam int DIV_LAST  = DIV_FIRST + DIV_STAGES - 1;
	localparam int ST_SQ     = DIV_LAST + 1;
	localparam int ST_PLO    = ST_SQ + 1;
	localparam int ST_PHI    = ST_PLO + 1;
	localparam int ST_SUM    = ST_PHI + 1;
	localparam int ST_HUE    = ST_SUM + 1;
	localparam int ST_VF     = ST_HUE + 1;
	localparam int ST_OUT    = ST_VF + 1;
	localparam int NSTG      = ST_OUT;

	localparam int POS_W = ENTRY_IDX_W + STEP_W;
	localparam int X2_W  = 2 * STEP_W;
	localparam int W_W   = STEP_W + 1;
	localparam int PP_W  = STEP_W + W_W;
	localparam int SUM_W = PP_W + STEP_W;
	localparam int H6_W  = Q16_W + 3;

	localparam logic [ENTRY_IDX_W-1:0] IDX_LAST = ENTRY_IDX_W'(MAX_ENTRIES - 1);
	localparam logic [W_W-1:0]         THREE_Q16 = W_W'(3 * 65536);

	// configuration registers
	logic [STEP_W-1:0] position_step_q;
	logic [Q16_W-1:0]  contrast_bottom_q;
	logic [Q16_W-1:0]  contrast_top_q;
	logic [Q16_W-1:0]  brightness_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_step_q   <= RST_POSITION_STEP;
			contrast_bottom_q <= RST_CONTRAST_BOTTOM;
			contrast_top_q    <= RST_CONTRAST_TOP;
			brightness_q      <= RST_BRIGHTNESS;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_POSITION_STEP:   position_step_q   <= cfg.data;
				REG_CONTRAST_BOTTOM: contrast_bottom_q <= cfg.data[Q16_W-1:0];
				REG_CONTRAST_TOP:    contrast_top_q    <= cfg.data[Q16_W-1:0];
				REG_BRIGHTNESS:      brightness_q      <= cfg.data[Q16_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline flow control: a stage loads when empty or when it moves on
	logic [NSTG:1] vld_s;
	logic [NSTG:1] en;

	always_comb begin
		en[NSTG] = !vld_s[NSTG] || result.ready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign item.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[1]) vld_s[1] <= item.valid;
			for (int k = 2; k <= NSTG; k++) begin
				if (en[k]) vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// stage 1: position product
	logic [ENTRY_IDX_W-1:0] idx_c;
	logic [POS_W-1:0]       pos_s1;

	always_comb begin
		if (32'(item.entry_index) >= MAX_ENTRIES) idx_c = IDX_LAST;
		else idx_c = item.entry_index;
	end

	always_ff @(posedge clk) begin
		if (en[ST_IDX]) pos_s1 <= POS_W'(idx_c) * POS_W'(position_step_q);
	end

	// stage 2: saturate, range check against the contrast window
	logic [Q16_W-1:0] rem_s [ST_RANGE:DIV_LAST];
	logic [Q16_W-1:0] quo_s [ST_RANGE:DIV_LAST];
	logic             frc_s [ST_RANGE:DIV_LAST];
	logic             one_s [ST_RANGE:DIV_LAST];
	logic [Q16_W-1:0] d_c;
	logic             frc_c;
	logic             one_c;
	logic [Q16_W-1:0] den;

	assign den = contrast_top_q - contrast_bottom_q;

	always_comb begin
		if (pos_s1 > POS_W'(16'hFFFF)) d_c = 16'hFFFF;
		else d_c = pos_s1[Q16_W-1:0];
		frc_c = 1'b1;
		one_c = 1'b0;
		if (contrast_top_q <= contrast_bottom_q) begin
			one_c = d_c >= contrast_bottom_q;
		end else if (d_c <= contrast_bottom_q) begin
			one_c = 1'b0;
		end else if (d_c >= contrast_top_q) begin
			one_c = 1'b1;
		end else begin
			frc_c = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_RANGE]) begin
			rem_s[ST_RANGE] <= d_c - contrast_bottom_q;
			quo_s[ST_RANGE] <= '0;
			frc_s[ST_RANGE] <= frc_c;
			one_s[ST_RANGE] <= one_c;
		end
	end

	// restoring divider, DIV_BITS quotient bits per stage
	for (genvar k = DIV_FIRST; k <= DIV_LAST; k++) begin : g_div
		logic [Q16_W-1:0] rem_n;
		logic [Q16_W-1:0] quo_n;

		always_comb begin
			logic [Q16_W:0] trial;
			rem_n = rem_s[k-1];
			quo_n = quo_s[k-1];
			for (int b = 0; b < DIV_BITS; b++) begin
				trial = {rem_n, 1'b0};
				if (trial >= {1'b0, den}) begin
					rem_n = Q16_W'(trial - {1'b0, den});
					quo_n = {quo_n[Q16_W-2:0], 1'b1};
				end else begin
					rem_n = trial[Q16_W-1:0];
					quo_n = {quo_n[Q16_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k] <= rem_n;
				quo_s[k] <= quo_n;
				frc_s[k] <= frc_s[k-1];
				one_s[k] <= one_s[k-1];
			end
		end
	end

	// smoothstep weight 3 - 2x and x squared
	logic [STEP_W-1:0] x_c;
	logic [X2_W-1:0]   x2_s11;
	logic [W_W-1:0]    w_s11;

	always_comb begin
		if (frc_s[DIV_LAST]) x_c = one_s[DIV_LAST] ? ONE_Q16 : '0;
		else x_c = {1'b0, quo_s[DIV_LAST]};
	end

	always_ff @(posedge clk) begin
		if (en[ST_SQ]) begin
			x2_s11 <= X2_W'(x_c) * X2_W'(x_c);
			w_s11  <= THREE_Q16 - {x_c, 1'b0};
		end
	end

	// x^2 * w as two partial products
	logic [PP_W-1:0]   pa_s12;
	logic [STEP_W-1:0] hi_s12;
	logic [W_W-1:0]    w_s12;
	logic [PP_W-1:0]   pb_s13;
	logic [PP_W-1:0]   pa_s13;

	always_ff @(posedge clk) begin
		if (en[ST_PLO]) begin
			pa_s12 <= PP_W'(x2_s11[STEP_W-1:0]) * PP_W'(w_s11);
			hi_s12 <= x2_s11[X2_W-1:STEP_W];
			w_s12  <= w_s11;
		end
		if (en[ST_PHI]) begin
			pb_s13 <= PP_W'(hi_s12) * PP_W'(w_s12);
			pa_s13 <= pa_s12;
		end
	end

	// hue fraction s in Q16, 0..1.0
	logic [SUM_W-1:0]  sum_c;
	logic [STEP_W-1:0] s_s14;

	assign sum_c = {pb_s13, {STEP_W{1'b0}}} + SUM_W'(pa_s13);

	always_ff @(posedge clk) begin
		if (en[ST_SUM]) s_s14 <= sum_c[32 +: STEP_W];
	end

	// hue in sixths of a turn, full turn wraps to zero
	logic [H6_W-1:0]  h6_c;
	sector_t          sec_s15;
	logic [Q16_W-1:0] f_s15;

	always_comb begin
		if (s_s14[Q16_W]) h6_c = '0;
		else h6_c = {1'b0, s_s14[Q16_W-1:0], 2'b00} + {2'b00, s_s14[Q16_W-1:0], 1'b0};
	end

	always_ff @(posedge clk) begin
		if (en[ST_HUE]) begin
			sec_s15 <= sector_t'(h6_c[H6_W-1:Q16_W]);
			f_s15   <= h6_c[Q16_W-1:0];
		end
	end

	// value times fraction
	logic [2*Q16_W-1:0] vf_s16;
	sector_t            sec_s16;

	always_ff @(posedge clk) begin
		if (en[ST_VF]) begin
			vf_s16  <= (2*Q16_W)'(brightness_q) * (2*Q16_W)'(f_s15);
			sec_s16 <= sec_s15;
		end
	end

	// rising q, falling p, sector select into the output register
	logic [Q16_W-1:0] q_c;
	logic [Q16_W-1:0] p_c;
	logic [Q16_W-1:0] red_c;
	logic [Q16_W-1:0] green_c;
	logic [Q16_W-1:0] blue_c;
	logic [Q16_W-1:0] red_s17;
	logic [Q16_W-1:0] green_s17;
	logic [Q16_W-1:0] blue_s17;

	always_comb begin
		q_c = vf_s16[2*Q16_W-1:Q16_W];
		p_c = brightness_q - q_c - Q16_W'(vf_s16[Q16_W-1:0] != '0);
		case (sec_s16)
			SEC_R_G: begin
				red_c = brightness_q; green_c = q_c; blue_c = '0;
			end
			SEC_G_R: begin
				red_c = p_c; green_c = brightness_q; blue_c = '0;
			end
			SEC_G_B: begin
				red_c = '0; green_c = brightness_q; blue_c = q_c;
			end
			SEC_B_G: begin
				red_c = '0; green_c = p_c; blue_c = brightness_q;
			end
			SEC_B_R: begin
				red_c = q_c; green_c = '0; blue_c = brightness_q;
			end
			default: begin
				red_c = brightness_q; green_c = '0; blue_c = p_c;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[ST_OUT]) begin
			red_s17   <= red_c;
			green_s17 <= green_c;
			blue_s17  <= blue_c;
		end
	end

	assign result.valid = vld_s[NSTG];
	assign result.red   = red_s17;
	assign result.green = green_s17;
	assign result.blue  = blue_s17;

endmodule
